// ===== hdl/pfa_pkg.sv =====
// Shared package of the page frame allocator: operation and status codes,
// configuration register indexes, field widths and control structs.
// No dependencies.
`timescale 1ns / 1ps

package pfa_pkg;

  // Field widths fixed by the interface
  localparam int unsigned OP_W     = 2;
  localparam int unsigned FRAME_W  = 16;
  localparam int unsigned OWNER_W  = 32;
  localparam int unsigned ENTRY_W  = 14;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LIMIT_W  = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  // Default storage depths
  localparam int unsigned STACK_DEPTH_DEF = 65536;
  localparam int unsigned LOG_DEPTH_DEF   = 16384;

  // Reset value of the upper frame limit
  localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RST = 17'd57344;

  // Operations
  localparam logic [OP_W-1:0] OP_FREE  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Result status
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FRAME = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_EN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWEST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd2;

  // Free stack commands and status
  typedef struct packed {
    logic rd_en;    // fetch the top entry
    logic push_en;  // write a frame at the top and grow
    logic pop_en;   // drop the top entry and the one below it
  } stk_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stk_sts_t;

  // Allocation log commands
  typedef struct packed {
    logic rd_en;    // fetch one entry
    logic app_en;   // append one entry if there is room
  } log_ctl_t;

endpackage

// ===== hdl/pfa_stack.sv =====
// Free frame stack: synchronous memory of frame numbers plus the fill count.
// Depends on pfa_pkg.
`timescale 1ns / 1ps

module pfa_stack #(
  parameter int unsigned DEPTH = 65536
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pfa_pkg::stk_ctl_t            ctl,
  input  logic [pfa_pkg::FRAME_W-1:0]  push_frame,
  output logic [pfa_pkg::FRAME_W-1:0]  top_frame,
  output pfa_pkg::stk_sts_t            sts
);
  import pfa_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [FRAME_W-1:0] mem [DEPTH];
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      count_m1;
  logic [FRAME_W-1:0] top_r;

  assign count_m1  = count_r - CW'(1);
  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == CW'(DEPTH));
  assign top_frame = top_r;

  // A pop takes two entries, or the last one when only one is left
  always_comb begin
    count_nxt = count_r;
    if (ctl.push_en) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.pop_en) begin
      count_nxt = (count_r > CW'(1)) ? count_r - CW'(2) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push_en) begin
      mem[count_r[AW-1:0]] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      top_r <= mem[count_m1[AW-1:0]];
    end
  end

endmodule

// ===== hdl/pfa_log.sv =====
// Allocation log: synchronous memory of {frame, owner} entries and its fill
// count. Entries at or above the count read as zero. Depends on pfa_pkg.
`timescale 1ns / 1ps

module pfa_log #(
  parameter int unsigned DEPTH = 16384
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pfa_pkg::log_ctl_t                   ctl,
  input  logic [pfa_pkg::ENTRY_W-1:0]         rd_index,
  input  logic [pfa_pkg::FRAME_W-1:0]         app_frame,
  input  logic [pfa_pkg::OWNER_W-1:0]         app_owner,
  output logic [pfa_pkg::FRAME_W-1:0]         rd_frame,
  output logic [pfa_pkg::OWNER_W-1:0]         rd_owner
);
  import pfa_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned DW = FRAME_W + OWNER_W;

  logic [DW-1:0]  mem [DEPTH];
  logic [CW-1:0]  count_r, count_nxt;
  logic [DW-1:0]  rd_r;
  logic           hit_r;
  logic           room;
  logic           hit;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  wr_addr;

  assign room    = (count_r != CW'(DEPTH));
  assign hit     = (32'(rd_index) < 32'(count_r));
  assign rd_addr = AW'(rd_index);
  assign wr_addr = AW'(count_r);

  assign count_nxt = (ctl.app_en && room) ? count_r + CW'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.app_en && room) begin
      mem[wr_addr] <= {app_frame, app_owner};
    end
  end

  // Hold the hit flag with the data: an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_r  <= mem[rd_addr];
      hit_r <= hit;
    end
  end

  assign rd_frame = hit_r ? rd_r[DW-1:OWNER_W] : '0;
  assign rd_owner = hit_r ? rd_r[OWNER_W-1:0] : '0;

endmodule

// ===== hdl/page_frame_allocator_with_log.sv =====
// Page frame allocator with allocation log: top level with the control
// sequencer, configuration registers and result register.
// Depends on pfa_pkg, pfa_stack and pfa_log.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_*): one operation per transfer. in_op selects free
//   (push in_frame_number after a range check), allocate (pop and grant the
//   top frame, discard the one below it, log frame and in_owner_id while
//   logging is on and the log has room) or read (return log entry
//   in_entry_index).
//   Result channel (out_*): exactly one result per operation, in order.
//   Configuration port (cfg_*): write log_enabled, lowest_frame and
//   frame_limit by index while the block is idle.
//   Sequence: the accept edge issues the read of the free stack or log
//   memory; the edge that finishes the operation lands the result in the
//   output register and commits the stack and log writes. in_ready rises
//   again in the same cycle, so the block takes a new operation only once
//   the last one has finished.
//   Stall: a result waits in the output register; the next operation may
//   still be taken, and it then holds in its execute state until the
//   pending result is transferred.
//   Reset: stack and log counts clear; log entries beyond the count read
//   as zero, so no clearing pass is needed and the block is ready at once.
module page_frame_allocator_with_log #(
  parameter int unsigned STACK_DEPTH = pfa_pkg::STACK_DEPTH_DEF,
  parameter int unsigned LOG_DEPTH   = pfa_pkg::LOG_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [pfa_pkg::OP_W-1:0]             in_op,
  input  logic [pfa_pkg::FRAME_W-1:0]          in_frame_number,
  input  logic signed [pfa_pkg::OWNER_W-1:0]   in_owner_id,
  input  logic [pfa_pkg::ENTRY_W-1:0]          in_entry_index,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [pfa_pkg::STATUS_W-1:0]         out_status,
  output logic [pfa_pkg::FRAME_W-1:0]          out_granted_frame,
  output logic [pfa_pkg::FRAME_W-1:0]          out_logged_frame,
  output logic signed [pfa_pkg::OWNER_W-1:0]   out_logged_owner,
  // configuration port
  input  logic                                 cfg_we,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pfa_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import pfa_pkg::*;

  // Sequencer states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                 state_r, state_nxt;
  logic                 accept;
  logic                 done;

  // Configuration
  logic                 log_en_r;
  logic [FRAME_W-1:0]   lowest_r;
  logic [LIMIT_W-1:0]   limit_r;

  // Operation held while it executes
  logic [OP_W-1:0]      op_r;
  logic [FRAME_W-1:0]   frame_r;
  logic [OWNER_W-1:0]   owner_r;

  // Result register
  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  status_r;
  logic [FRAME_W-1:0]   granted_r;
  logic [FRAME_W-1:0]   lframe_r;
  logic [OWNER_W-1:0]   lowner_r;

  // Result being formed
  logic [STATUS_W-1:0]  status_c;
  logic [FRAME_W-1:0]   granted_c;
  logic [FRAME_W-1:0]   lframe_c;
  logic [OWNER_W-1:0]   lowner_c;
  logic                 push_c;
  logic                 pop_c;

  stk_ctl_t             stk_ctl;
  stk_sts_t             stk_sts;
  logic [FRAME_W-1:0]   stk_top;
  log_ctl_t             log_ctl;
  logic [FRAME_W-1:0]   log_frame;
  logic [OWNER_W-1:0]   log_owner;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  // Finish once the output register is free or being drained
  assign done     = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_en_r <= 1'b0;
      lowest_r <= '0;
      limit_r  <= FRAME_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOG_EN: log_en_r <= cfg_data[0];
        CFG_LOWEST: lowest_r <= cfg_data[FRAME_W-1:0];
        CFG_LIMIT:  limit_r  <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_EXEC;
      S_EXEC: if (done)   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the operation on its transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_op;
      frame_r <= in_frame_number;
      owner_r <= in_owner_id;
    end
  end

  // Issue memory reads on the accept edge; data is there in the next cycle
  always_comb begin
    stk_ctl.rd_en   = accept && (in_op == OP_ALLOC);
    stk_ctl.push_en = done && push_c;
    stk_ctl.pop_en  = done && pop_c;
    log_ctl.rd_en   = accept && (in_op == OP_READ);
    log_ctl.app_en  = done && pop_c && log_en_r;
  end

  // Form the result from the fetched data and the current counts
  always_comb begin
    status_c  = ST_OK;
    granted_c = '0;
    lframe_c  = '0;
    lowner_c  = '0;
    push_c    = 1'b0;
    pop_c     = 1'b0;
    unique case (op_r)
      OP_FREE: begin
        if (frame_r < lowest_r || {1'b0, frame_r} >= limit_r) begin
          status_c = ST_RANGE;
        end else if (stk_sts.full) begin
          status_c = ST_FULL;
        end else begin
          push_c = 1'b1;
        end
      end
      OP_ALLOC: begin
        if (stk_sts.empty) begin
          status_c = ST_NO_FRAME;
        end else begin
          granted_c = stk_top;
          pop_c     = 1'b1;
        end
      end
      OP_READ: begin
        lframe_c = log_frame;
        lowner_c = log_owner;
      end
      default: ;  // unused op: no state change, all fields zero
    endcase
  end

  // Output register: load on finish, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      status_r  <= status_c;
      granted_r <= granted_c;
      lframe_r  <= lframe_c;
      lowner_r  <= lowner_c;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_granted_frame = granted_r;
  assign out_logged_frame  = lframe_r;
  assign out_logged_owner  = lowner_r;

  pfa_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (stk_ctl),
    .push_frame (frame_r),
    .top_frame  (stk_top),
    .sts        (stk_sts)
  );

  pfa_log #(
    .DEPTH (LOG_DEPTH)
  ) u_log (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (log_ctl),
    .rd_index  (in_entry_index),
    .app_frame (stk_top),
    .app_owner (owner_r),
    .rd_frame  (log_frame),
    .rd_owner  (log_owner)
  );

endmodule

// ===== hdl/pfa_checker.sv =====
// Port-level checks for the page frame allocator, bound to the top level.
// Depends on pfa_pkg and page_frame_allocator_with_log.
`timescale 1ns / 1ps

module pfa_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic [pfa_pkg::STATUS_W-1:0]         out_status,
  input  logic [pfa_pkg::FRAME_W-1:0]          out_granted_frame,
  input  logic [pfa_pkg::FRAME_W-1:0]          out_logged_frame,
  input  logic signed [pfa_pkg::OWNER_W-1:0]   out_logged_owner
);
  import pfa_pkg::*;

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_granted_frame) && $stable(out_logged_frame)
      && $stable(out_logged_owner))
    else $error("result changed while stalled");

  // One operation at a time: a transfer drops in_ready in the cycle after it
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // Failed operations grant nothing and read nothing
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NO_FRAME || out_status == ST_RANGE
      || out_status == ST_FULL) |-> out_granted_frame == '0
      && out_logged_frame == '0 && out_logged_owner == '0)
    else $error("failed operation carries data");

  // No result straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind page_frame_allocator_with_log pfa_checker u_pfa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_granted_frame (out_granted_frame),
  .out_logged_frame  (out_logged_frame),
  .out_logged_owner  (out_logged_owner)
);

// ===== verif/tb.sv =====
// Self-checking bench for page_frame_allocator_with_log: directed and random
// free, allocate and log-read traffic, with results checked against a model.
// Depends on pfa_pkg and page_frame_allocator_with_log.
`timescale 1ns / 1ps

module tb;
  import pfa_pkg::*;

  // Stack and log at their specified depths.
  localparam int unsigned FREE_DEPTH   = STACK_DEPTH_DEF;
  localparam int unsigned LOG_SLOTS    = LOG_DEPTH_DEF;
  // Op code 3 is unused by the block; it must change nothing and answer zeros.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam logic signed [OWNER_W-1:0] KERNEL_OWNER = -32'sd2;
  localparam logic signed [OWNER_W-1:0] MAX_OWNER    = 32'sh7fffffff;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned RX_HOLD      = 300;
  // Cycles with no transfer on either channel before the run is abandoned.
  localparam int unsigned STALL_LIMIT  = 3000;

  typedef struct {
    logic [STATUS_W-1:0]       status;
    logic [FRAME_W-1:0]        granted;
    logic [FRAME_W-1:0]        lframe;
    logic signed [OWNER_W-1:0] lowner;
  } frame_result_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [OP_W-1:0]             in_op;
  logic [FRAME_W-1:0]          in_frame_number;
  logic signed [OWNER_W-1:0]   in_owner_id;
  logic [ENTRY_W-1:0]          in_entry_index;
  logic                        out_valid;
  logic                        out_ready;
  logic [STATUS_W-1:0]         out_status;
  logic [FRAME_W-1:0]          out_granted_frame;
  logic [FRAME_W-1:0]          out_logged_frame;
  logic signed [OWNER_W-1:0]   out_logged_owner;
  logic                        cfg_we;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]       cfg_data;

  // Shadow of the allocator: free stack, log and configuration registers.
  logic [FRAME_W-1:0]          free_frames [FREE_DEPTH];
  int unsigned                 free_top;
  logic [FRAME_W-1:0]          log_frame_copy [LOG_SLOTS];
  logic signed [OWNER_W-1:0]   log_owner_copy [LOG_SLOTS];
  int unsigned                 log_fill;
  logic                        log_on;
  logic [FRAME_W-1:0]          low_frame;
  logic [LIMIT_W-1:0]          top_limit;

  // Results still owed by the block, oldest first.
  frame_result_t               expected_results [$];
  int unsigned                 fail_count;
  int unsigned                 quiet_cycles;

  // Idling controls: the sender and receiver each leave gaps while these are
  // set; rx_hold_request asks the receiver for one long hold-off.
  bit                          tx_gaps;
  bit                          rx_gaps;
  int unsigned                 rx_hold_request;

  page_frame_allocator_with_log #(
    .STACK_DEPTH(FREE_DEPTH),
    .LOG_DEPTH  (LOG_SLOTS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_frame_number  (in_frame_number),
    .in_owner_id      (in_owner_id),
    .in_entry_index   (in_entry_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_granted_frame(out_granted_frame),
    .out_logged_frame (out_logged_frame),
    .out_logged_owner (out_logged_owner),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Work out the result of one accepted operation and advance the shadow
  // state exactly as the block should.
  task automatic predict_frame_op(input logic [OP_W-1:0] op,
                                  input logic [FRAME_W-1:0] frame,
                                  input logic signed [OWNER_W-1:0] owner,
                                  input logic [ENTRY_W-1:0] entry);
    frame_result_t r;
    r.status  = ST_OK;
    r.granted = '0;
    r.lframe  = '0;
    r.lowner  = '0;
    case (op)
      OP_FREE: begin
        // Range check first, so an out-of-range frame on a full stack still
        // reports a range error.
        if (frame < low_frame || {1'b0, frame} >= top_limit) begin
          r.status = ST_RANGE;
        end else if (free_top >= FREE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          free_frames[free_top] = frame;
          free_top++;
        end
      end
      OP_ALLOC: begin
        if (free_top == 0) begin
          r.status = ST_NO_FRAME;
        end else begin
          free_top--;
          r.granted = free_frames[free_top];
          // Drop the frame below as a blank page; a lone frame just empties
          // the stack.
          if (free_top > 0) free_top--;
          if (log_on && log_fill < LOG_SLOTS) begin
            log_frame_copy[log_fill] = r.granted;
            log_owner_copy[log_fill] = owner;
            log_fill++;
          end
        end
      end
      OP_READ: begin
        // Indexes at or beyond the log depth answer zeros.
        if (entry < LOG_SLOTS) begin
          r.lframe = log_frame_copy[entry];
          r.lowner = log_owner_copy[entry];
        end
      end
      default: ;
    endcase
    expected_results.push_back(r);
  endtask

  // Offer one operation and hold it until the transfer; then, while gaps are
  // enabled, sometimes drop valid and idle. Valid is left high when
  // no gap follows, so back-to-back items never toggle it within one step.
  task automatic issue_op(input logic [OP_W-1:0] op,
                          input logic [FRAME_W-1:0] frame,
                          input logic signed [OWNER_W-1:0] owner,
                          input logic [ENTRY_W-1:0] entry);
    in_valid        <= 1'b1;
    in_op           <= op;
    in_frame_number <= frame;
    in_owner_id     <= owner;
    in_entry_index  <= entry;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_frame_op(op, frame, owner, entry);
    if (tx_gaps && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Stop offering, wait for every owed result, then let the block finish
  // committing before the registers are touched.
  task automatic settle_idle();
    if (in_valid) in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LOG_EN: log_on    = value[0];
      CFG_LOWEST: low_frame = value[FRAME_W-1:0];
      CFG_LIMIT:  top_limit = value[LIMIT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic log_en,
                                input logic [FRAME_W-1:0] lowest,
                                input logic [LIMIT_W-1:0] limit);
    settle_idle();
    write_reg(CFG_LOG_EN, CFG_DATA_W'(log_en));
    write_reg(CFG_LOWEST, CFG_DATA_W'(lowest));
    write_reg(CFG_LIMIT,  CFG_DATA_W'(limit));
  endtask

  // One random operation. Frames lean towards the legal window, entries
  // towards the log, owners now and then take the kernel value or -1.
  task automatic random_frame_op(input int free_pct, input int alloc_pct);
    logic [OP_W-1:0]           op;
    logic [FRAME_W-1:0]        frame;
    logic signed [OWNER_W-1:0] owner;
    logic [ENTRY_W-1:0]        entry;
    int                        pick;
    pick = $urandom_range(0, 99);
    if (pick < free_pct)                  op = OP_FREE;
    else if (pick < free_pct + alloc_pct) op = OP_ALLOC;
    else if (pick < 97)                   op = OP_READ;
    else                                  op = OP_SPARE;
    if (top_limit > {1'b0, low_frame} && $urandom_range(0, 99) < 80)
      frame = FRAME_W'($urandom_range(int'(low_frame), int'(top_limit) - 1));
    else
      frame = FRAME_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 10)      owner = KERNEL_OWNER;
    else if (pick < 13) owner = -32'sd1;
    else                owner = signed'({1'b0, 31'($urandom)});
    if ($urandom_range(0, 99) < 85) entry = ENTRY_W'($urandom_range(0, log_fill + 3));
    else                            entry = ENTRY_W'($urandom);
    issue_op(op, frame, owner, entry);
  endtask

  // Fresh log reads zeros, allocate on an empty stack, the spare op code and
  // a read of the last log entry.
  task automatic test_empty_and_unused();
    issue_op(OP_READ,  '0, '0, '0);
    issue_op(OP_ALLOC, '0, KERNEL_OWNER, '0);
    issue_op(OP_SPARE, '1, -32'sd1, '1);
    issue_op(OP_READ,  '1, MAX_OWNER, '1);
  endtask

  // Frees at and around the window edges, including the widest and the
  // narrowest windows.
  task automatic test_range_check();
    apply_settings(1'b0, 16'd100, 17'd200);
    issue_op(OP_FREE, 16'd99,  '0, '0);
    issue_op(OP_FREE, 16'd100, '0, '0);
    issue_op(OP_FREE, 16'd199, '0, '0);
    issue_op(OP_FREE, 16'd200, '0, '0);
    apply_settings(1'b0, 16'd0, 17'd65536);
    issue_op(OP_FREE, 16'd0,     '0, '0);
    issue_op(OP_FREE, 16'hffff,  '0, '0);
    apply_settings(1'b0, 16'hffff, 17'd1);
    issue_op(OP_FREE, 16'd0,     '0, '0);
    issue_op(OP_FREE, 16'hffff,  '0, '0);
  endtask

  // Grants with logging on: each grant swallows the frame below it, a lone
  // frame is still granted, and the log keeps frame and owner.
  task automatic test_grant_and_log();
    apply_settings(1'b1, 16'd0, 17'd65536);
    issue_op(OP_ALLOC, '0, KERNEL_OWNER, '0);
    issue_op(OP_ALLOC, '0, MAX_OWNER, '0);
    issue_op(OP_FREE,  16'd7, '0, '0);
    issue_op(OP_ALLOC, '0, -32'sd1, '0);
    issue_op(OP_ALLOC, '0, '0, '0);
    issue_op(OP_READ,  '0, '0, 14'd0);
    issue_op(OP_READ,  '0, '0, 14'd1);
    issue_op(OP_READ,  '0, '0, 14'd2);
    issue_op(OP_READ,  '0, '0, ENTRY_W'(LOG_SLOTS - 1));
  endtask

  // Hold the receiver off for a long stretch while the sender keeps
  // offering back to back, so results back up and in_ready falls.
  task automatic test_receiver_hold_off();
    settle_idle();
    tx_gaps = 1'b0;
    rx_hold_request = RX_HOLD;
    repeat (24) random_frame_op(55, 30);
    tx_gaps = 1'b1;
  endtask

  // Random traffic in phases. Even phases lean towards frees and fill the
  // stack, odd phases towards grants and drain it. Phase 2 runs with no
  // idling on either side.
  task automatic test_random_traffic();
    int unsigned lo;
    int unsigned hi;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: apply_settings(1'b1, 16'd0, 17'd65536);
        1: apply_settings(1'b0, 16'h1000, 17'h09000);
        2: begin
          lo = $urandom_range(0, 60000);
          hi = $urandom_range(lo + 1, 65536);
          apply_settings(1'b1, FRAME_W'(lo), LIMIT_W'(hi));
        end
        3: apply_settings(1'b0, 16'd0, FRAME_LIMIT_RST);
        4: apply_settings(1'b1, 16'd0, 17'd1);
        default: apply_settings(1'b1, 16'hffff, 17'd65536);
      endcase
      tx_gaps = (phase != 2);
      rx_gaps = (phase != 2);
      repeat (RANDOM_ITEMS / 6) begin
        if (phase % 2 == 0) random_frame_op(55, 25);
        else                random_frame_op(25, 50);
      end
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  // Receiver: accept with random idling, or hold off for a requested
  // number of cycles counted here.
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_request != 0) begin
        hold_left = rx_hold_request;
        rx_hold_request = 0;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (rx_gaps) begin
        out_ready <= ($urandom_range(0, 99) >= 29);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest owed result.
  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with none owed: status %0d granted_frame %0d",
               out_status, out_granted_frame);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_granted_frame !== want.granted) begin
          $error("granted_frame: expected %0d, got %0d", want.granted, out_granted_frame);
          fail_count++;
        end
        if (out_logged_frame !== want.lframe) begin
          $error("logged_frame: expected %0d, got %0d", want.lframe, out_logged_frame);
          fail_count++;
        end
        if (out_logged_owner !== want.lowner) begin
          $error("logged_owner: expected %0d, got %0d", want.lowner, out_logged_owner);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: abandon the run after a long stretch without any transfer.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("page_frame_allocator_with_log verification failed");
      $finish;
    end
  end

  initial begin
    // Drive every input to a known value and clear the shadow state.
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_op           = OP_FREE;
    in_frame_number = '0;
    in_owner_id     = '0;
    in_entry_index  = '0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_LOG_EN;
    cfg_data        = '0;
    tx_gaps         = 1'b1;
    rx_gaps         = 1'b1;
    rx_hold_request = 0;
    fail_count      = 0;
    quiet_cycles    = 0;
    free_top        = 0;
    log_fill        = 0;
    log_on          = 1'b0;
    low_frame       = '0;
    top_limit       = FRAME_LIMIT_RST;
    for (int i = 0; i < FREE_DEPTH; i++) free_frames[i] = '0;
    for (int i = 0; i < LOG_SLOTS; i++) begin
      log_frame_copy[i] = '0;
      log_owner_copy[i] = '0;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_unused();
    test_range_check();
    test_grant_and_log();
    test_receiver_hold_off();
    test_random_traffic();

    // Drain: wait for every owed result, then watch for strays.
    settle_idle();
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("page_frame_allocator_with_log verification clean");
    end else begin
      $display("page_frame_allocator_with_log verification failed");
    end
    $finish;
  end

endmodule
